@@ sv/tdwq_pkg.sv @@
// Shared types and codes for the tick delay wake-up queue.
// Used by the queue top level, its sequencer datapath and its port checker.
`default_nettype none

package tdwq_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_TIME  = 3'd1,
      OP_DELAY = 3'd2,
      OP_UNTIL = 3'd3
   } opcode_type;

   // Reply kinds carried on rsp_tuser
   typedef enum logic [2:0] {
      ST_WOKEN   = 3'd0,
      ST_TIME    = 3'd1,
      ST_IMMED   = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_REPLY,
      S_TK_RD,
      S_TK_CHK,
      S_INS_RD,
      S_INS_CHK
   } state_type;

   localparam int unsigned TICK_W = 32;
   localparam int unsigned REPLY_TO_W = 8;
   localparam logic [TICK_W-1:0] VALUE_UNKNOWN = '1;

endpackage

`default_nettype wire

@@ sv/tdwq_ram.sv @@
// Single-port-write, single-port-read store for the sorted waiter ring.
// Read data is registered; no reset, entries are undefined until written.
`default_nettype none

module tdwq_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 40,
   parameter int unsigned AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry a cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/tdwq_unit.sv @@
// Shared add-and-compare unit: sum = a + b, le = (sum <= c), unsigned.
// Depends on tdwq_pkg for the tick width.
`default_nettype none

module tdwq_unit
   import tdwq_pkg::*;
(
   input  wire logic [TICK_W-1:0] a,
   input  wire logic [TICK_W-1:0] b,
   input  wire logic [TICK_W-1:0] c,
   output logic      [TICK_W-1:0] sum,
   output logic                   le
);

   // Wrap the sum at the tick width, then compare
   always_comb begin
      sum = a + b;
      le  = (sum <= c);
   end

endmodule

`default_nettype wire

@@ sv/tick_delay_wakeup_queue.sv @@
// Time queries and unknown, immediate or store-full requests pass calc, then the reply state.
// A stored delay passes calc, a read and check pair per waiter moved up one place, a last
// read, and a check if an earlier waiter stays put. A tick passes calc, a read and check pair
// per woken waiter, a last read, and a check if a waiter is left not due. A stalled reply
// holds the reply and tick states. One request at a time; req_tready is high only while idle.
// Synchronous reset clears the tick count and empties the ring; no clearing pass.
`default_nettype none

module tick_delay_wakeup_queue
   import tdwq_pkg::*;
#(
   parameter int unsigned MAX_WAITERS  = 64,
   parameter int unsigned TASK_ID_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [7:0] task_id, [39:8] tick_value
   input  wire logic [2:0]  req_tuser,   // [2:0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] reply_to, [39:8] reply_value
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic             rsp_tlast    // last reply for this request
);

   localparam int unsigned IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
   localparam int unsigned EW = TICK_W + TASK_ID_BITS;
   localparam int unsigned WB = (TASK_ID_BITS < REPLY_TO_W) ? TASK_ID_BITS : REPLY_TO_W;
   localparam logic [IW:0]   DEPTH_EXT = (IW + 1)'(MAX_WAITERS);
   localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_WAITERS - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_WAITERS);

   // Ring slot of an offset from the head
   function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] head,
                                               input logic [IW-1:0] off);
      logic [IW:0] s;
      s = {1'b0, head} + {1'b0, off};
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[IW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [2:0]              op_ff, op_in;
   logic [TASK_ID_BITS-1:0] who_ff, who_in;
   logic [TICK_W-1:0]       val_ff, val_in;
   logic [TICK_W-1:0]       count_ff, count_in;
   logic [IW-1:0]           head_ff, head_in;
   logic [CW-1:0]           entries_ff, entries_in;
   logic [IW-1:0]           j_ff, j_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [TASK_ID_BITS-1:0] pend_who_ff, pend_who_in;
   status_type              rep_status_ff, rep_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [REPLY_TO_W-1:0]   reply_to_ff, reply_to_in;
   logic [TICK_W-1:0]       reply_value_ff, reply_value_in;
   logic [2:0]              status_ff, status_in;
   logic                    last_ff, last_in;

   logic                    req_fire;
   logic                    out_free;
   logic                    emit;
   logic [TASK_ID_BITS-1:0] emit_who;
   logic [TICK_W-1:0]       emit_value;
   status_type              emit_status;
   logic                    emit_last;

   logic [TICK_W-1:0]       u_a, u_b, u_c, u_sum;
   logic                    u_le;

   logic                    wr_en;
   logic [IW-1:0]           wr_addr, rd_addr;
   logic [EW-1:0]           wr_data, rd_data;
   logic [TICK_W-1:0]       rd_when;
   logic [TASK_ID_BITS-1:0] rd_who;
   logic [IW-1:0]           j_dec;
   logic                    is_full, is_empty;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_when    = rd_data[EW-1:TASK_ID_BITS];
   assign rd_who     = rd_data[TASK_ID_BITS-1:0];
   assign j_dec      = j_ff - IW'(1);
   assign is_full    = (entries_ff == FULL_CNT);
   assign is_empty   = (entries_ff == '0);

   tdwq_unit u_unit (
      .a   (u_a),
      .b   (u_b),
      .c   (u_c),
      .sum (u_sum),
      .le  (u_le)
   );

   tdwq_ram #(
      .DEPTH (MAX_WAITERS),
      .WIDTH (EW),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Steer the shared unit
   always_comb begin
      u_a = val_ff;
      u_b = '0;
      u_c = count_ff;
      case (state_ff)
         S_CALC: begin
            if (op_ff == OP_TICK) begin
               u_a = count_ff;
               u_b = TICK_W'(1);
            end else if (op_ff == OP_DELAY) begin
               u_b = count_ff;
            end
         end
         S_TK_CHK: begin
            u_a = rd_when;
         end
         S_INS_CHK: begin
            u_a = rd_when;
            u_c = val_ff;
         end
         default: begin
            u_a = val_ff;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_CALC;
         end
         S_CALC: begin
            if (op_ff == OP_TICK) begin
               state_in = S_TK_RD;
            end else if ((op_ff == OP_DELAY || op_ff == OP_UNTIL) && !u_le && !is_full) begin
               state_in = S_INS_RD;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (out_free) state_in = S_IDLE;
         end
         S_TK_RD: begin
            if (!is_empty) begin
               state_in = S_TK_CHK;
            end else if (!pend_valid_ff || out_free) begin
               state_in = S_IDLE;
            end
         end
         S_TK_CHK: begin
            if (!pend_valid_ff || out_free) begin
               state_in = u_le ? S_TK_RD : S_IDLE;
            end
         end
         S_INS_RD: begin
            state_in = (j_ff == '0) ? S_IDLE : S_INS_CHK;
         end
         S_INS_CHK: begin
            state_in = u_le ? S_IDLE : S_INS_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and reply control per state
   always_comb begin
      op_in         = op_ff;
      who_in        = who_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      entries_in    = entries_ff;
      j_in          = j_ff;
      pend_valid_in = pend_valid_ff;
      pend_who_in   = pend_who_ff;
      rep_status_in = rep_status_ff;
      emit          = 1'b0;
      emit_who      = pend_who_ff;
      emit_value    = count_ff;
      emit_status   = ST_WOKEN;
      emit_last     = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = ring_slot(head_ff, j_ff);
      wr_data       = {val_ff, who_ff};
      rd_addr       = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in  = req_tuser;
               who_in = TASK_ID_BITS'(req_tdata[WB-1:0]);
               val_in = req_tdata[39:8];
            end
         end
         S_CALC: begin
            case (op_ff)
               OP_TICK: begin
                  count_in      = u_sum;
                  pend_valid_in = 1'b0;
               end
               OP_TIME: begin
                  rep_status_in = ST_TIME;
               end
               OP_DELAY, OP_UNTIL: begin
                  val_in = u_sum;
                  j_in   = entries_ff[IW-1:0];
                  if (u_le) begin
                     rep_status_in = ST_IMMED;
                  end else if (is_full) begin
                     rep_status_in = ST_FULL;
                  end
               end
               default: begin
                  rep_status_in = ST_UNKNOWN;
               end
            endcase
         end
         S_REPLY: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_who    = who_ff;
               emit_status = rep_status_ff;
               emit_value  = (rep_status_ff == ST_UNKNOWN) ? VALUE_UNKNOWN : count_ff;
            end
         end
         S_TK_RD: begin
            // Flush the held wake-up as the last reply once the ring runs dry
            if (is_empty && pend_valid_ff && out_free) begin
               emit          = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         S_TK_CHK: begin
            if (!pend_valid_ff || out_free) begin
               emit      = pend_valid_ff;
               emit_last = !u_le;
               if (u_le) begin
                  // Pop the due head and hold it until the next one is known
                  pend_valid_in = 1'b1;
                  pend_who_in   = rd_who;
                  head_in       = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
                  entries_in    = entries_ff - CW'(1);
               end else begin
                  pend_valid_in = 1'b0;
               end
            end
         end
         S_INS_RD: begin
            rd_addr = ring_slot(head_ff, j_dec);
            if (j_ff == '0) begin
               wr_en      = 1'b1;
               entries_in = entries_ff + CW'(1);
            end
         end
         S_INS_CHK: begin
            rd_addr = ring_slot(head_ff, j_dec);
            wr_en   = 1'b1;
            if (u_le) begin
               entries_in = entries_ff + CW'(1);
            end else begin
               // Move the later waiter up one place
               wr_data = rd_data;
               j_in    = j_dec;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Load the reply register when a beat is emitted, drop it when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      reply_to_in    = reply_to_ff;
      reply_value_in = reply_value_ff;
      status_in      = status_ff;
      last_in        = last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         reply_to_in    = REPLY_TO_W'(emit_who[WB-1:0]);
         reply_value_in = emit_value;
         status_in      = emit_status;
         last_in        = emit_last;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         entries_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         entries_ff    <= entries_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      who_ff         <= who_in;
      val_ff         <= val_in;
      j_ff           <= j_in;
      pend_who_ff    <= pend_who_in;
      rep_status_ff  <= rep_status_in;
      reply_to_ff    <= reply_to_in;
      reply_value_ff <= reply_value_in;
      status_ff      <= status_in;
      last_ff        <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {reply_value_ff, reply_to_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

@@ sv/tdwq_chk.sv @@
// Port-level checker for the tick delay wake-up queue, bound to the top level.
// Depends on tdwq_pkg for the reply status codes.
`default_nettype none

module tdwq_chk
   import tdwq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // Come out of reset idle with no reply pending
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (req_tready && !rsp_tvalid))
      else $error("queue not idle after reset");

   // A request beat makes the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // Only wake-ups come in runs; every other reply ends its request
   a_single_reply_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_WOKEN) |-> rsp_tlast)
      else $error("non wake-up reply without tlast");

   // Hold a stalled reply beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled reply beat changed");

endmodule

bind tick_delay_wakeup_queue tdwq_chk u_tdwq_chk (.*);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tick_delay_wakeup_queue: directed, full-store and random tests.
// Holds its own predictor of tick count and sorted waiter store; needs tdwq_pkg and the RTL.

module tb_top;
   import tdwq_pkg::*;

   localparam int unsigned STORE_DEPTH = 64;
   localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd4;

   typedef struct packed {
      logic [7:0]  reply_to;
      logic [31:0] reply_value;
      status_type  status;
      logic        last;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [7:0] task_id, [39:8] tick_value
   logic [2:0]  req_tuser = '0;   // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [7:0] reply_to, [39:8] reply_value
   logic [2:0]  rsp_tuser;        // [2:0] status
   logic        rsp_tlast;

   // predicted state of the queue
   logic [31:0] tick_now = '0;
   logic [31:0] waiter_due [STORE_DEPTH];
   logic [7:0]  waiter_task [STORE_DEPTH];
   int unsigned waiter_count = 0;
   reply_type   pending_replies [$];

   int unsigned mismatch_count = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_gap_left = 0;

   tick_delay_wakeup_queue #(
      .MAX_WAITERS  (STORE_DEPTH),
      .TASK_ID_BITS (8)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_reply(logic [7:0] who, logic [31:0] value, status_type st);
      reply_type r;
      r.reply_to    = who;
      r.reply_value = value;
      r.status      = st;
      r.last        = 1'b0;
      pending_replies.push_back(r);
   endfunction

   // Update the predicted store for one accepted request and queue its replies
   function automatic void predict_replies(logic [2:0] op, logic [7:0] who, logic [31:0] value);
      logic [31:0] due;
      int unsigned woken, pos, added;
      added = 0;
      case (op)
         OP_TICK: begin
            tick_now = tick_now + 32'd1;
            woken = 0;
            while (woken < waiter_count && waiter_due[woken] <= tick_now) begin
               push_reply(waiter_task[woken], tick_now, ST_WOKEN);
               woken++;
            end
            added = woken;
            for (int j = woken; j < waiter_count; j++) begin
               waiter_due[j - woken]  = waiter_due[j];
               waiter_task[j - woken] = waiter_task[j];
            end
            waiter_count -= woken;
         end
         OP_TIME: begin
            push_reply(who, tick_now, ST_TIME);
            added = 1;
         end
         OP_DELAY, OP_UNTIL: begin
            due = (op == OP_DELAY) ? value + tick_now : value;
            added = 1;
            if (due <= tick_now) begin
               push_reply(who, tick_now, ST_IMMED);
            end else if (waiter_count >= STORE_DEPTH) begin
               push_reply(who, tick_now, ST_FULL);
            end else begin
               // insert behind every waiter due at or before this one
               added = 0;
               pos = 0;
               while (pos < waiter_count && waiter_due[pos] <= due) pos++;
               for (int j = waiter_count; j > pos; j--) begin
                  waiter_due[j]  = waiter_due[j - 1];
                  waiter_task[j] = waiter_task[j - 1];
               end
               waiter_due[pos]  = due;
               waiter_task[pos] = who;
               waiter_count++;
            end
         end
         default: begin
            push_reply(who, VALUE_UNKNOWN, ST_UNKNOWN);
            added = 1;
         end
      endcase
      if (added != 0) pending_replies[pending_replies.size() - 1].last = 1'b1;
   endfunction

   // Offer one request beat and wait for it to be taken; valid stays high afterwards
   task automatic send_request(input logic [2:0] op, input logic [7:0] who,
                               input logic [31:0] value);
      int unsigned gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, who};
      do @(posedge clock); while (!req_tready);
      predict_replies(op, who, value);
   endtask

   // Drop valid and wait for every queued reply, with a cap
   task automatic wait_for_replies();
      int unsigned waited;
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_replies.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_replies.size() != 0) begin
         $display("%0t: %0d expected replies never arrived", $time, pending_replies.size());
         mismatch_count += pending_replies.size();
         pending_replies.delete();
      end
   endtask

   task automatic test_basic_ops();
      // tick with nothing due, time queries at the id extremes
      send_request(OP_TICK, 8'h00, 32'h0000_0000);
      send_request(OP_TIME, 8'h00, 32'hFFFF_FFFF);
      send_request(OP_TIME, 8'hFF, 32'h0000_0000);
      for (int k = 0; k < 4; k++)
         send_request(OP_UNKNOWN_FIRST + 3'(k), 8'hA5 ^ 8'(k),
                      (k % 2) ? 32'hFFFF_FFFF : 32'h0);
      // deadlines already reached, including a relative one that wraps
      send_request(OP_DELAY, 8'd1, 32'd0);
      send_request(OP_UNTIL, 8'd2, 32'd0);
      send_request(OP_UNTIL, 8'd3, tick_now);
      send_request(OP_DELAY, 8'd4, 32'hFFFF_FFFF);
      // far deadlines that need an unsigned compare; these stay parked
      send_request(OP_UNTIL, 8'd5, 32'hFFFF_FFFF);
      send_request(OP_DELAY, 8'd6, 32'h8000_0000);
      send_request(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
      wait_for_replies();
   endtask

   task automatic test_deadline_order();
      // equal deadlines must leave in arrival order
      send_request(OP_DELAY, 8'd10, 32'd2);
      send_request(OP_UNTIL, 8'd11, tick_now + 32'd2);
      send_request(OP_DELAY, 8'd12, 32'd1);
      send_request(OP_UNTIL, 8'd13, tick_now + 32'd1);
      send_request(OP_DELAY, 8'd14, 32'd3);
      repeat (4) send_request(OP_TICK, 8'h3C, 32'h0);
      wait_for_replies();
   endtask

   task automatic test_store_full();
      int unsigned id;
      id = 100;
      // fill every free slot with the same near deadline
      while (waiter_count < STORE_DEPTH) begin
         if (id % 2) send_request(OP_DELAY, id[7:0], 32'd4);
         else        send_request(OP_UNTIL, id[7:0], tick_now + 32'd4);
         id++;
      end
      send_request(OP_DELAY, 8'hEE, 32'd4);
      send_request(OP_UNTIL, 8'hEF, tick_now + 32'd9);
      wait_for_replies();
      // stall the reply side while a mass wake and queries pile up behind it
      req_idle_on   = 1'b0;
      rsp_hold_left = 400;
      repeat (4) send_request(OP_TICK, 8'h00, 32'h0);
      for (int k = 0; k < 6; k++) send_request(OP_TIME, k[7:0], 32'h0);
      wait_for_replies();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int unsigned r, back;
      logic [2:0]  op;
      logic [31:0] value;
      for (int n = 0; n < 16; n++) begin
         // rotate through idle combinations, including none at all
         if (n % 4 == 0) begin
            req_idle_on = ((n / 4) % 2) != 0;
            rsp_idle_on = (n / 8) == 0;
         end
         r = $urandom_range(0, 99);
         value = $urandom;
         if (r < 30) op = OP_TICK;
         else if (r < 40) op = OP_TIME;
         else if (r < 65) op = OP_DELAY;
         else if (r < 90) op = OP_UNTIL;
         else op = OP_UNKNOWN_FIRST + 3'($urandom_range(0, 3));
         back = (tick_now < 6) ? tick_now : 6;
         r = $urandom_range(0, 99);
         if (op == OP_DELAY) begin
            if (r < 70) value = $urandom_range(1, 8);
            else if (r < 88) value = 32'd0;
            else if (r < 97) value = 32'd0 - $urandom_range(0, back);
         end else if (op == OP_UNTIL) begin
            if (r < 60) value = tick_now + $urandom_range(1, 8);
            else if (r < 88) value = tick_now - $urandom_range(0, back);
            else if (r < 96) value = $urandom_range(0, 20);
         end
         send_request(op, 8'($urandom_range(0, 255)), value);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      wait_for_replies();
   endtask

   // Reply-side ready: random stalls, plus a long hold when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap_left != 0) begin
         rsp_gap_left = rsp_gap_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_gap_left = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each reply beat against the oldest expectation
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply to=%0d value=%0h status=%0d last=%0b", $time,
                     rsp_tdata[7:0], rsp_tdata[39:8], rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[7:0] !== want.reply_to) begin
               $display("%0t: reply_to expected %0d actual %0d", $time,
                        want.reply_to, rsp_tdata[7:0]);
               mismatch_count++;
            end
            if (rsp_tdata[39:8] !== want.reply_value) begin
               $display("%0t: reply_value expected %0h actual %0h", $time,
                        want.reply_value, rsp_tdata[39:8]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_deadline_order();
      test_store_full();
      test_random_traffic();
      wait_for_replies();
      // let any stray reply show up before the verdict
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ tick_delay_wakeup_queue.f @@
sv/tdwq_pkg.sv
sv/tdwq_ram.sv
sv/tdwq_unit.sv
sv/tick_delay_wakeup_queue.sv
sv/tdwq_chk.sv
sim/tb_top.sv
